// ===== rtl/core/lru_ast_pkg.sv =====
// types, codes and constants shared by the lru asset slot table
// no dependencies
`default_nettype none

package lru_ast_pkg;

    localparam int DEF_SLOT_COUNT = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int SLOT_IDX_W     = 6;

    localparam logic [11:0] RST_MAX_WIDTH  = 12'd320;
    localparam logic [11:0] RST_MAX_HEIGHT = 12'd240;
    localparam logic [23:0] RST_MAX_PIXELS = 24'(200 * 1024 / 2);
    localparam logic [31:0] STAMP_NONE     = 32'hFFFF_FFFF;

    localparam logic [1:0] OP_LOOKUP    = 2'd0;
    localparam logic [1:0] OP_LOAD_OK   = 2'd1;
    localparam logic [1:0] OP_LOAD_FAIL = 2'd2;

    localparam logic [1:0] CFG_MAX_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_MAX_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MAX_PIXELS = 2'd2;

    localparam logic [2:0] STATUS_HIT       = 3'd0;
    localparam logic [2:0] STATUS_RESERVED  = 3'd1;
    localparam logic [2:0] STATUS_NO_SLOT   = 3'd2;
    localparam logic [2:0] STATUS_PUBLISHED = 3'd3;
    localparam logic [2:0] STATUS_MERGED    = 3'd4;
    localparam logic [2:0] STATUS_RELEASED  = 3'd5;
    localparam logic [2:0] STATUS_EMPTY     = 3'd6;
    localparam logic [2:0] STATUS_BAD_SLOT  = 3'd7;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] asset_key;
        logic [3:0]  slot_index;
        logic [11:0] loaded_width;
        logic [11:0] loaded_height;
    } lru_ast_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_out;
        logic        evicted_loaded;
        logic [11:0] width_out;
        logic [11:0] height_out;
    } lru_ast_out_t;

    // running result handed from cell to cell
    typedef struct packed {
        logic                  match_found;
        logic [SLOT_IDX_W-1:0] match_idx;
        logic [11:0]           match_width;
        logic [11:0]           match_height;
        logic                  free_found;
        logic [SLOT_IDX_W-1:0] free_idx;
        logic                  min_found;
        logic [SLOT_IDX_W-1:0] min_idx;
        logic [31:0]           min_stamp;
        logic                  min_loaded;
        logic                  sel_used;
        logic                  sel_loaded;
    } lru_ast_scan_t;

    // write command broadcast to all cells
    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] idx;
        logic                  wr_used;
        logic                  used_val;
        logic                  wr_loaded;
        logic                  loaded_val;
        logic                  wr_key;
        logic                  wr_dims;
        logic                  wr_stamp;
        logic [11:0]           width;
        logic [11:0]           height;
        logic [31:0]           stamp;
    } lru_ast_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_WRITE_A,
        ST_WRITE_B,
        ST_RESULT
    } lru_ast_state_t;

    localparam lru_ast_scan_t SCAN_INIT = '{
        match_found: 1'b0, match_idx: '0, match_width: '0, match_height: '0,
        free_found: 1'b0, free_idx: '0, min_found: 1'b0, min_idx: '0,
        min_stamp: STAMP_NONE, min_loaded: 1'b0, sel_used: 1'b0, sel_loaded: 1'b0
    };

    localparam lru_ast_cmd_t CMD_NONE = '{
        en: 1'b0, idx: '0, wr_used: 1'b0, used_val: 1'b0, wr_loaded: 1'b0,
        loaded_val: 1'b0, wr_key: 1'b0, wr_dims: 1'b0, wr_stamp: 1'b0,
        width: '0, height: '0, stamp: '0
    };

endpackage

`default_nettype wire

// ===== rtl/core/lru_ast_cell.sv =====
// one directory slot: holds its state and folds itself into the passing scan word
// depends on lru_ast_pkg
`default_nettype none

module lru_ast_cell #(
    parameter int ID       = 0,
    parameter int KEY_BITS = lru_ast_pkg::DEF_KEY_BITS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic [KEY_BITS-1:0]                   cmp_key,
    input  wire logic                                  excl_en,
    input  wire logic [lru_ast_pkg::SLOT_IDX_W-1:0]    tgt_idx,
    input  wire lru_ast_pkg::lru_ast_scan_t            scan_in,
    input  wire logic [KEY_BITS-1:0]                   key_in,
    output lru_ast_pkg::lru_ast_scan_t                 scan_out,
    output logic [KEY_BITS-1:0]                        key_out,
    input  wire lru_ast_pkg::lru_ast_cmd_t             cmd,
    input  wire logic [KEY_BITS-1:0]                   wr_key
);
    import lru_ast_pkg::*;

    localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(ID);

    logic                used_reg, loaded_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [11:0]         width_reg, height_reg;
    logic [31:0]         stamp_reg;
    lru_ast_scan_t       scan_reg, scan_next;
    logic [KEY_BITS-1:0] keyc_reg, keyc_next;

    logic is_tgt, local_match, my_cmd;

    assign is_tgt      = (tgt_idx == MY_IDX);
    assign local_match = used_reg && loaded_reg && (key_reg == cmp_key) && !(excl_en && is_tgt);
    assign my_cmd      = cmd.en && (cmd.idx == MY_IDX);

    always_comb begin
        scan_next = scan_in;
        keyc_next = key_in;
        if (!scan_in.match_found && local_match) begin
            scan_next.match_found  = 1'b1;
            scan_next.match_idx    = MY_IDX;
            scan_next.match_width  = width_reg;
            scan_next.match_height = height_reg;
        end
        if (!scan_in.free_found && !used_reg) begin
            scan_next.free_found = 1'b1;
            scan_next.free_idx   = MY_IDX;
        end
        if (used_reg && (stamp_reg < scan_in.min_stamp)) begin
            scan_next.min_found  = 1'b1;
            scan_next.min_idx    = MY_IDX;
            scan_next.min_stamp  = stamp_reg;
            scan_next.min_loaded = loaded_reg;
        end
        if (is_tgt) begin
            scan_next.sel_used   = used_reg;
            scan_next.sel_loaded = loaded_reg;
            keyc_next            = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
        keyc_reg <= keyc_next;
    end

    assign scan_out = scan_reg;
    assign key_out  = keyc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg   <= 1'b0;
            loaded_reg <= 1'b0;
        end else if (my_cmd) begin
            if (cmd.wr_used) begin
                used_reg <= cmd.used_val;
            end
            if (cmd.wr_loaded) begin
                loaded_reg <= cmd.loaded_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (my_cmd) begin
            if (cmd.wr_key) begin
                key_reg <= wr_key;
            end
            if (cmd.wr_dims) begin
                width_reg  <= cmd.width;
                height_reg <= cmd.height;
            end
            if (cmd.wr_stamp) begin
                stamp_reg <= cmd.stamp;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lru_asset_slot_table.sv =====
// lru asset slot table: a fully associative slot directory with lru replacement
// Channels: s_valid/s_ready/s_data takes one request word (lookup, load ok,
// load failed); m_valid/m_ready/m_data returns exactly one result word per
// request. cfg_valid/cfg_ready/cfg_index/cfg_data writes the size limits
// (index 0 max width, 1 max height, 2 max pixels); cfg_ready is always high.
// The slots form a row of SLOT_COUNT cells; a scan word walks the row one
// cell per clock. An empty key or unknown operation goes straight to the
// result; a bad slot or a lookup that finds no slot goes to the result
// after the scan; any other lookup or a release also writes a slot;
// publish and merge scan the row again with the slot's key, then publish
// writes its slot and a merge writes both the slot and the matched one.
// One request is in flight at a time: s_ready is high only when idle, so no
// new word is taken before the last result is accepted.
// Reset (aresetn low, synchronous) frees every slot, clears the lookup tick
// and restores the default limits. A stalled receiver holds m_data and the
// block takes no new word until the result is taken.
// depends on lru_ast_pkg and lru_ast_cell
`default_nettype none

module lru_asset_slot_table #(
    parameter int SLOT_COUNT = lru_ast_pkg::DEF_SLOT_COUNT,
    parameter int KEY_BITS   = lru_ast_pkg::DEF_KEY_BITS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire lru_ast_pkg::lru_ast_in_t  s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output lru_ast_pkg::lru_ast_out_t      m_data,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [23:0]               cfg_data
);
    import lru_ast_pkg::*;

    localparam int CNT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOT_COUNT - 1);

    lru_ast_state_t state_reg, state_next;
    lru_ast_in_t    req_reg, req_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] cmp_key_reg, cmp_key_next;
    logic           pass2_reg, pass2_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [23:0]    pix_reg, pix_next;
    logic [31:0]    tick_reg, tick_next;
    lru_ast_cmd_t   cmd_a_reg, cmd_a_next, cmd_b_reg, cmd_b_next;
    lru_ast_out_t   res_reg, res_next;
    logic [11:0]    max_width_reg, max_height_reg;
    logic [23:0]    max_pixels_reg;

    lru_ast_scan_t       scan_bus [SLOT_COUNT+1];
    logic [KEY_BITS-1:0] key_bus  [SLOT_COUNT+1];
    lru_ast_cmd_t        cmd;
    lru_ast_scan_t       fin;
    logic [KEY_BITS-1:0] in_key;
    logic                accept;
    logic                dec_load, dec_bad, dec_release, dec_rescan, idx_oor, over_limit;

    assign scan_bus[0] = SCAN_INIT;
    assign key_bus[0]  = '0;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        lru_ast_cell #(
            .ID       (g),
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmp_key  (cmp_key_reg),
            .excl_en  (pass2_reg),
            .tgt_idx  (SLOT_IDX_W'(req_reg.slot_index)),
            .scan_in  (scan_bus[g]),
            .key_in   (key_bus[g]),
            .scan_out (scan_bus[g+1]),
            .key_out  (key_bus[g+1]),
            .cmd      (cmd),
            .wr_key   (key_reg)
        );
    end

    assign fin    = scan_bus[SLOT_COUNT];
    assign in_key = KEY_BITS'(s_data.asset_key);
    assign accept = s_valid && s_ready;

    // config registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_width_reg  <= RST_MAX_WIDTH;
            max_height_reg <= RST_MAX_HEIGHT;
            max_pixels_reg <= RST_MAX_PIXELS;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MAX_WIDTH:  max_width_reg  <= cfg_data[11:0];
                CFG_MAX_HEIGHT: max_height_reg <= cfg_data[11:0];
                CFG_MAX_PIXELS: max_pixels_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // decision on the finished scan
    always_comb begin
        dec_load    = (req_reg.operation != OP_LOOKUP);
        idx_oor     = (32'(req_reg.slot_index) >= 32'(SLOT_COUNT));
        over_limit  = (req_reg.loaded_width == '0) || (req_reg.loaded_height == '0) ||
                      (req_reg.loaded_width > max_width_reg) ||
                      (req_reg.loaded_height > max_height_reg) ||
                      (pix_reg > max_pixels_reg);
        dec_bad     = dec_load && !pass2_reg && (idx_oor || !fin.sel_used || fin.sel_loaded);
        dec_release = dec_load && !pass2_reg && !dec_bad &&
                      ((req_reg.operation == OP_LOAD_FAIL) || over_limit);
        dec_rescan  = dec_load && !pass2_reg && !dec_bad && !dec_release;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if ((s_data.operation == OP_LOOKUP && in_key == '0) ||
                        (s_data.operation != OP_LOOKUP && s_data.operation != OP_LOAD_OK &&
                         s_data.operation != OP_LOAD_FAIL)) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (count_reg == CNT_LAST) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (dec_rescan) begin
                    state_next = ST_SCAN;
                end else if (dec_bad || (!dec_load && !fin.match_found &&
                                          !fin.free_found && !fin.min_found)) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_WRITE_A;
                end
            end
            ST_WRITE_A: state_next = cmd_b_reg.en ? ST_WRITE_B : ST_RESULT;
            ST_WRITE_B: state_next = ST_RESULT;
            ST_RESULT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        cmd     = CMD_NONE;
        case (state_reg)
            ST_IDLE:    s_ready = 1'b1;
            ST_WRITE_A: cmd = cmd_a_reg;
            ST_WRITE_B: cmd = cmd_b_reg;
            ST_RESULT:  m_valid = 1'b1;
            default: ;
        endcase
    end

    assign m_data = res_reg;

    // datapath
    always_comb begin
        req_next     = req_reg;
        key_next     = key_reg;
        cmp_key_next = cmp_key_reg;
        pass2_next   = pass2_reg;
        count_next   = count_reg;
        pix_next     = pix_reg;
        tick_next    = tick_reg;
        cmd_a_next   = cmd_a_reg;
        cmd_b_next   = cmd_b_reg;
        res_next     = res_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next     = s_data;
                    key_next     = in_key;
                    cmp_key_next = in_key;
                    pass2_next   = 1'b0;
                    count_next   = '0;
                    pix_next     = s_data.loaded_width * s_data.loaded_height;
                    res_next     = '0;
                    res_next.status = STATUS_BAD_SLOT;
                    if (s_data.operation == OP_LOOKUP) begin
                        if (in_key == '0) begin
                            res_next.status = STATUS_EMPTY;
                        end else begin
                            tick_next = tick_reg + 32'd1;
                        end
                    end
                end
            end
            ST_SCAN: count_next = count_reg + CNT_W'(1);
            ST_DECIDE: begin
                count_next = '0;
                cmd_a_next = CMD_NONE;
                cmd_b_next = CMD_NONE;
                res_next   = '0;
                if (dec_rescan) begin
                    cmp_key_next = key_bus[SLOT_COUNT];
                    pass2_next   = 1'b1;
                end else if (dec_bad) begin
                    res_next.status = STATUS_BAD_SLOT;
                end else if (dec_release) begin
                    cmd_a_next.en      = 1'b1;
                    cmd_a_next.idx     = SLOT_IDX_W'(req_reg.slot_index);
                    cmd_a_next.wr_used = 1'b1;
                    res_next.status    = STATUS_RELEASED;
                    res_next.slot_out  = req_reg.slot_index;
                end else if (dec_load) begin
                    if (fin.match_found) begin
                        cmd_a_next.en        = 1'b1;
                        cmd_a_next.idx       = SLOT_IDX_W'(req_reg.slot_index);
                        cmd_a_next.wr_used   = 1'b1;
                        cmd_a_next.wr_loaded = 1'b1;
                        cmd_b_next.en        = 1'b1;
                        cmd_b_next.idx       = fin.match_idx;
                        cmd_b_next.wr_stamp  = 1'b1;
                        cmd_b_next.stamp     = tick_reg;
                        res_next.status      = STATUS_MERGED;
                        res_next.slot_out    = fin.match_idx[3:0];
                        res_next.width_out   = fin.match_width;
                        res_next.height_out  = fin.match_height;
                    end else begin
                        cmd_a_next.en         = 1'b1;
                        cmd_a_next.idx        = SLOT_IDX_W'(req_reg.slot_index);
                        cmd_a_next.wr_loaded  = 1'b1;
                        cmd_a_next.loaded_val = 1'b1;
                        cmd_a_next.wr_dims    = 1'b1;
                        cmd_a_next.width      = req_reg.loaded_width;
                        cmd_a_next.height     = req_reg.loaded_height;
                        cmd_a_next.wr_stamp   = 1'b1;
                        cmd_a_next.stamp      = tick_reg;
                        res_next.status       = STATUS_PUBLISHED;
                        res_next.slot_out     = req_reg.slot_index;
                        res_next.width_out    = req_reg.loaded_width;
                        res_next.height_out   = req_reg.loaded_height;
                    end
                end else if (fin.match_found) begin
                    cmd_a_next.en       = 1'b1;
                    cmd_a_next.idx      = fin.match_idx;
                    cmd_a_next.wr_stamp = 1'b1;
                    cmd_a_next.stamp    = tick_reg;
                    res_next.status     = STATUS_HIT;
                    res_next.slot_out   = fin.match_idx[3:0];
                    res_next.width_out  = fin.match_width;
                    res_next.height_out = fin.match_height;
                end else if (fin.free_found || fin.min_found) begin
                    cmd_a_next.en         = 1'b1;
                    cmd_a_next.idx        = fin.free_found ? fin.free_idx : fin.min_idx;
                    cmd_a_next.wr_used    = 1'b1;
                    cmd_a_next.used_val   = 1'b1;
                    cmd_a_next.wr_loaded  = 1'b1;
                    cmd_a_next.wr_key     = 1'b1;
                    res_next.status       = STATUS_RESERVED;
                    res_next.slot_out     = fin.free_found ? fin.free_idx[3:0]
                                                           : fin.min_idx[3:0];
                    res_next.evicted_loaded = !fin.free_found && fin.min_loaded;
                end else begin
                    res_next.status = STATUS_NO_SLOT;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tick_reg  <= '0;
            pass2_reg <= 1'b0;
            count_reg <= '0;
            cmd_a_reg <= CMD_NONE;
            cmd_b_reg <= CMD_NONE;
        end else begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            pass2_reg <= pass2_next;
            count_reg <= count_next;
            cmd_a_reg <= cmd_a_next;
            cmd_b_reg <= cmd_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        key_reg     <= key_next;
        cmp_key_reg <= cmp_key_next;
        pix_reg     <= pix_next;
        res_reg     <= res_next;
    end

`ifndef NO_ASSERTIONS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request and result sides active together");

    a_tick_only_on_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && s_data.operation == OP_LOOKUP && in_key != '0) |=> $stable(tick_reg))
        else $error("lookup tick moved without a lookup");

    a_hit_has_dims: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_HIT) |-> (m_data.width_out != '0))
        else $error("hit returned a slot that was never published");

    a_reserve_no_dims: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_RESERVED) |->
        (m_data.width_out == '0 && m_data.height_out == '0))
        else $error("reservation carries dimensions");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_lru_asset_slot_table.sv =====
// self-checking bench for the lru asset slot table: directed and random request words
// with randomized valid/ready idling, checked against an in-bench directory predictor
// depends on lru_ast_pkg and lru_asset_slot_table
`default_nettype none

module tb_lru_asset_slot_table;
    import lru_ast_pkg::*;

    localparam int NSLOT = 16;
    localparam int LIMIT = 400000;

    class slot_table_scoreboard;
        bit          used [NSLOT];
        bit          loaded [NSLOT];
        logic [31:0] key [NSLOT];
        logic [11:0] wid [NSLOT];
        logic [11:0] hgt [NSLOT];
        logic [31:0] stamp [NSLOT];
        logic [31:0] tick;
        logic [11:0] lim_w, lim_h;
        logic [23:0] lim_px;
        lru_ast_out_t pending [$];
        int errors;

        function void clear();
            for (int i = 0; i < NSLOT; i++) begin
                used[i] = 0; loaded[i] = 0; key[i] = 0; wid[i] = 0; hgt[i] = 0; stamp[i] = 0;
            end
            tick = 0; lim_w = RST_MAX_WIDTH; lim_h = RST_MAX_HEIGHT; lim_px = RST_MAX_PIXELS;
            errors = 0;
        endfunction

        function void set_limit(logic [1:0] idx, logic [23:0] val);
            if (idx == CFG_MAX_WIDTH) lim_w = val[11:0];
            else if (idx == CFG_MAX_HEIGHT) lim_h = val[11:0];
            else if (idx == CFG_MAX_PIXELS) lim_px = val;
        endfunction

        function void note_request(lru_ast_in_t w);
            lru_ast_out_t r;
            int pick, dup, ix;
            logic [31:0] least;
            r = '0;
            pick = -1;
            dup = -1;
            least = STAMP_NONE;
            ix = w.slot_index;
            if (w.operation == OP_LOOKUP) begin
                if (w.asset_key == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    tick = tick + 1;
                    for (int i = 0; i < NSLOT; i++)
                        if (dup < 0 && used[i] && loaded[i] && key[i] == w.asset_key) dup = i;
                    if (dup >= 0) begin
                        stamp[dup] = tick;
                        r.status = STATUS_HIT; r.slot_out = dup;
                        r.width_out = wid[dup]; r.height_out = hgt[dup];
                    end else begin
                        for (int i = 0; i < NSLOT; i++)
                            if (pick < 0 && !used[i]) pick = i;
                        if (pick < 0)
                            for (int i = 0; i < NSLOT; i++)
                                if (used[i] && stamp[i] < least) begin
                                    least = stamp[i]; pick = i;
                                end
                        if (pick < 0) begin
                            r.status = STATUS_NO_SLOT;
                        end else begin
                            r.status = STATUS_RESERVED; r.slot_out = pick;
                            r.evicted_loaded = loaded[pick];
                            loaded[pick] = 0; used[pick] = 1; key[pick] = w.asset_key;
                        end
                    end
                end
            end else if (w.operation != OP_LOAD_OK && w.operation != OP_LOAD_FAIL) begin
                r.status = STATUS_BAD_SLOT;
            end else if (!used[ix] || loaded[ix]) begin
                r.status = STATUS_BAD_SLOT;
            end else if (w.operation == OP_LOAD_FAIL || w.loaded_width == 0 ||
                         w.loaded_height == 0 || w.loaded_width > lim_w ||
                         w.loaded_height > lim_h ||
                         24'(w.loaded_width) * 24'(w.loaded_height) > lim_px) begin
                used[ix] = 0;
                r.status = STATUS_RELEASED; r.slot_out = ix;
            end else begin
                for (int i = 0; i < NSLOT; i++)
                    if (dup < 0 && i != ix && used[i] && loaded[i] && key[i] == key[ix]) dup = i;
                if (dup >= 0) begin
                    used[ix] = 0; loaded[ix] = 0; stamp[dup] = tick;
                    r.status = STATUS_MERGED; r.slot_out = dup;
                    r.width_out = wid[dup]; r.height_out = hgt[dup];
                end else begin
                    loaded[ix] = 1; wid[ix] = w.loaded_width; hgt[ix] = w.loaded_height;
                    stamp[ix] = tick;
                    r.status = STATUS_PUBLISHED; r.slot_out = ix;
                    r.width_out = w.loaded_width; r.height_out = w.loaded_height;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(lru_ast_out_t got);
            lru_ast_out_t exp;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status || got.slot_out !== exp.slot_out ||
                got.evicted_loaded !== exp.evicted_loaded ||
                got.width_out !== exp.width_out || got.height_out !== exp.height_out) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                             exp.status, exp.slot_out, exp.evicted_loaded, exp.width_out,
                             exp.height_out, got.status, got.slot_out, got.evicted_loaded,
                             got.width_out, got.height_out);
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_valid = 0;
    logic         s_ready;
    lru_ast_in_t  s_data = '0;
    logic         m_valid;
    logic         m_ready = 0;
    lru_ast_out_t m_data;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [23:0]  cfg_data = '0;

    slot_table_scoreboard sb;
    int send_idle, recv_idle;
    int cycles;
    logic [31:0] key_pool [8];

    always #5 aclk = ~aclk;

    lru_asset_slot_table u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_lru_asset_slot_table: done, errors");
            $finish;
        end
    end

    // result side: check accepted words, stall at random
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_word(lru_ast_in_t w);
        @(posedge aclk);
        while ($urandom_range(99) < send_idle) @(posedge aclk);
        s_valid <= 1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(w);
        s_valid <= 0;
    endtask

    task automatic wait_drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_limit(logic [1:0] idx, logic [23:0] val);
        wait_drain();
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_limit(idx, val);
        cfg_valid <= 0;
    endtask

    function automatic lru_ast_in_t mk(logic [1:0] op, logic [31:0] k, logic [3:0] ix,
                                       logic [11:0] w, logic [11:0] h);
        lru_ast_in_t r;
        r.operation = op; r.asset_key = k; r.slot_index = ix;
        r.loaded_width = w; r.loaded_height = h;
        return r;
    endfunction

    // reserved slot whose stamp was never written; eviction must not reach it
    function automatic bit risky_evict();
        bit all_used;
        all_used = 1;
        for (int i = 0; i < NSLOT; i++) if (!sb.used[i]) all_used = 0;
        if (!all_used) return 0;
        for (int i = 0; i < NSLOT; i++) if (!sb.loaded[i] && sb.stamp[i] == 0) return 1;
        return 0;
    endfunction

    // true when the next lookup cannot cause a miss that evicts an unwritten stamp
    function automatic bit lookup_safe(logic [31:0] k);
        if (k == 0) return 1;
        for (int i = 0; i < NSLOT; i++)
            if (sb.used[i] && sb.loaded[i] && sb.key[i] == k) return 1;
        return !risky_evict();
    endfunction

    task automatic random_word();
        lru_ast_in_t w;
        int sel, ix;
        logic [31:0] k;
        sel = $urandom_range(99);
        ix = -1;
        for (int i = 0; i < NSLOT; i++)
            if (sb.used[i] && !sb.loaded[i] && $urandom_range(1)) ix = i;
        if (ix < 0)
            for (int i = 0; i < NSLOT; i++) if (sb.used[i] && !sb.loaded[i]) ix = i;
        if (sel < 45 || (sel < 85 && ix < 0)) begin
            k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(7)];
            if ($urandom_range(40) == 0) k = 0;
            if (!lookup_safe(k)) begin
                // publish a pending reservation ahead of the lookup
                for (int i = 0; i < NSLOT; i++) if (sb.used[i] && !sb.loaded[i]) ix = i;
                w = mk(OP_LOAD_OK, $urandom(), ix, $urandom_range(1, 100),
                       $urandom_range(1, 100));
                send_word(w);
                if (!lookup_safe(k)) k = sb.key[ix];
            end
            w = mk(OP_LOOKUP, k, $urandom(), $urandom(), $urandom());
        end else if (sel < 85) begin
            w = mk(($urandom_range(9) == 0) ? OP_LOAD_FAIL : OP_LOAD_OK, $urandom(), ix,
                   ($urandom_range(7) == 0) ? $urandom() : $urandom_range(1, sb.lim_w),
                   ($urandom_range(7) == 0) ? $urandom() : $urandom_range(1, sb.lim_h));
        end else begin
            w = mk($urandom_range(3), $urandom(), $urandom(), $urandom(), $urandom());
            if (w.operation == OP_LOOKUP) w.asset_key = key_pool[$urandom_range(7)];
            if (w.operation == OP_LOOKUP && !lookup_safe(w.asset_key)) w.operation = 2'd3;
        end
        send_word(w);
    endtask

    task automatic run_phase(int n);
        for (int i = 0; i < n; i++) begin
            random_word();
            if (i == n / 2) wait_drain();
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        cycles = 0;
        send_idle = 0;
        recv_idle = 0;
        foreach (key_pool[i]) key_pool[i] = $urandom_range(1, 60);
        key_pool[0] = 32'hFFFF_FFFF;
        key_pool[1] = 32'h8000_0000;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed
        send_word(mk(OP_LOOKUP, 0, 4'hF, 12'hFFF, 12'hFFF));
        send_word(mk(OP_LOAD_OK, 0, 0, 10, 10));
        send_word(mk(2'd3, 32'hFFFF_FFFF, 4'hF, 12'hFFF, 12'hFFF));
        send_word(mk(OP_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0));
        send_word(mk(OP_LOAD_OK, 0, 0, 320, 240));
        send_word(mk(OP_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0));
        send_word(mk(OP_LOAD_OK, 0, 0, 1, 1));
        send_word(mk(OP_LOOKUP, 7, 0, 0, 0));
        send_word(mk(OP_LOOKUP, 7, 0, 0, 0));
        send_word(mk(OP_LOAD_OK, 0, 2, 5, 6));
        send_word(mk(OP_LOAD_OK, 0, 1, 5, 6));
        send_word(mk(OP_LOOKUP, 9, 0, 0, 0));
        send_word(mk(OP_LOAD_OK, 0, 1, 321, 1));
        send_word(mk(OP_LOOKUP, 9, 0, 0, 0));
        send_word(mk(OP_LOAD_OK, 0, 1, 1, 241));
        send_word(mk(OP_LOOKUP, 9, 0, 0, 0));
        send_word(mk(OP_LOAD_OK, 0, 1, 0, 5));
        send_word(mk(OP_LOOKUP, 9, 0, 0, 0));
        send_word(mk(OP_LOAD_FAIL, 0, 1, 5, 5));
        send_word(mk(OP_LOOKUP, 9, 0, 0, 0));
        send_word(mk(OP_LOAD_OK, 0, 1, 320, 240));
        // fill every slot so the next misses evict
        for (int i = 0; i < 16; i++) begin
            send_word(mk(OP_LOOKUP, 100 + i, 0, 0, 0));
            if (sb.pending[$].status == STATUS_RESERVED)
                send_word(mk(OP_LOAD_OK, 0, sb.pending[$].slot_out, 3, 4));
        end
        send_word(mk(OP_LOOKUP, 500, 0, 0, 0));

        send_idle = 7; recv_idle = 86;
        run_phase(350);
        write_limit(CFG_MAX_WIDTH, 24'd4095);
        write_limit(CFG_MAX_HEIGHT, 24'd4095);
        write_limit(CFG_MAX_PIXELS, 24'hFFFFFF);
        send_idle = 86; recv_idle = 7;
        run_phase(350);
        write_limit(CFG_MAX_WIDTH, 24'd1);
        write_limit(CFG_MAX_HEIGHT, 24'd1);
        write_limit(CFG_MAX_PIXELS, 24'd1);
        send_idle = 0; recv_idle = 0;
        run_phase(150);
        write_limit(CFG_MAX_WIDTH, 24'd2000);
        write_limit(CFG_MAX_HEIGHT, 24'd3000);
        write_limit(CFG_MAX_PIXELS, 24'd500000);
        run_phase(500);

        wait_drain();
        if (sb.errors == 0) begin
            $display("tb_lru_asset_slot_table: done, clean");
        end else begin
            $display("tb_lru_asset_slot_table: done, errors");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== lru_asset_slot_table.f =====
rtl/core/lru_ast_pkg.sv
rtl/core/lru_ast_cell.sv
rtl/core/lru_asset_slot_table.sv
sim/tb_lru_asset_slot_table.sv
